// ===== hw/rtl/rdsc_pkg.sv =====
`timescale 1ns / 1ps

package rdsc_pkg;

  // Widths of the stream payloads and the configuration port
  localparam int unsigned InDataW  = 48;
  localparam int unsigned InUserW  = 3;
  localparam int unsigned OutDataW = 24;
  localparam int unsigned CfgAddrW = 5;
  localparam int unsigned CfgDataW = 32;

  localparam int unsigned PowerupTicksDefault = 100;
  localparam logic [6:0]  MaxLevelPct = 7'd100;

  // Command and event codes
  typedef enum logic [2:0] {
    ACT_SET_DIMMER    = 3'd0,
    ACT_SET_RELAY     = 3'd1,
    ACT_SET_INTENSITY = 3'd2,
    ACT_TICK          = 3'd3,
    ACT_DIMMER_FAULT  = 3'd4,
    ACT_SWITCH_FAULT  = 3'd5,
    ACT_GOING_TO_DFU  = 3'd6,
    ACT_UNUSED        = 3'd7
  } action_t;

  // Forced-event report codes
  typedef enum logic [1:0] {
    FORCED_NONE      = 2'd0,
    FORCED_RELAY_ON  = 2'd1,
    FORCED_SWITCH_OFF = 2'd2
  } forced_t;

  // Configuration register indexes (byte address / 4)
  typedef enum logic [2:0] {
    REG_SWITCHING_ALLOWED   = 3'd0,
    REG_DIMMING_ALLOWED     = 3'd1,
    REG_BOOT_DIM_TRY        = 3'd2,
    REG_POWER_THRESHOLD     = 3'd3,
    REG_POWER_THRESHOLD_UNC = 3'd4,
    REG_POWER_ZERO_CAL      = 3'd5,
    REG_CHECK_DELAY         = 3'd6,
    REG_NONE                = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic        switching_allowed;
    logic        dimming_allowed;
    logic        boot_dim_try_allowed;
    logic [15:0] power_threshold_mw;
    logic [15:0] power_threshold_uncal_mw;
    logic        power_zero_calibrated;
    logic [15:0] check_delay_ticks;
  } cfg_t;

  typedef struct packed {
    logic        want_relay;
    logic [6:0]  want_level;
    logic        saved_relay;
    logic [6:0]  saved_level;
    logic        out_relay;
    logic [7:0]  out_level;
    logic        power_checked;
    logic        power_measured;
    logic [15:0] powerup_count;
    logic [15:0] check_count;
    logic        store_req;
  } sup_t;

  // Dimmer circuit counts as powered once the power-up countdown ran out or power was seen
  function automatic logic circuit_powered(sup_t s);
    return (s.powerup_count == 16'd0) || s.power_measured;
  endfunction

  // Record the intended state, flag a store when it differs from the saved one
  function automatic sup_t save_state(sup_t s, logic relay, logic [6:0] level);
    sup_t r;
    r = s;
    r.want_relay = relay;
    r.want_level = level;
    if (relay != s.saved_relay || level != s.saved_level) begin
      r.saved_relay = relay;
      r.saved_level = level;
      r.store_req   = 1'b1;
    end
    return r;
  endfunction

  // Move the relay unless an interlock holds it
  function automatic sup_t drive_relay(sup_t s, logic on, logic overload, logic dimfail);
    sup_t r;
    r = s;
    if (on && !(dimfail || !overload)) begin
      r = s;
    end else if (!on && dimfail) begin
      r = s;
    end else begin
      r.out_relay = on;
    end
    return r;
  endfunction

  // Move the dimmer unless dimming is barred or unsafe
  function automatic sup_t drive_level(sup_t s, cfg_t c, logic [7:0] v, logic overload,
                                       logic dimfail);
    sup_t r;
    r = s;
    if (!(v != 8'd0 && (!c.dimming_allowed || dimfail || overload || !circuit_powered(s))))
      r.out_level = v;
    return r;
  endfunction

  // Drop to relay-only operation
  function automatic sup_t fall_back(sup_t s);
    sup_t r;
    r = s;
    r.out_relay = 1'b1;
    r.out_level = 8'd0;
    r = save_state(r, 1'b1, 7'd0);
    return r;
  endfunction

  // Bring the actual drive towards the intended state
  function automatic sup_t resolve(sup_t s, cfg_t c, logic overload, logic dimfail);
    sup_t r;
    logic safe_dim;
    logic pwr;
    logic lvl_nz;
    r = s;
    safe_dim = !dimfail && !overload;
    pwr      = circuit_powered(s);
    lvl_nz   = (s.want_level != 7'd0);
    if (s.want_relay ||
        (lvl_nz && (!c.dimming_allowed || !safe_dim || (!pwr && s.power_checked)))) begin
      r = drive_relay(r, 1'b1, overload, dimfail);
      r.out_level = 8'd0;
    end else if (c.dimming_allowed && !s.power_checked && !pwr && lvl_nz) begin
      if (!safe_dim || !c.boot_dim_try_allowed) begin
        r = fall_back(r);
      end else begin
        // Start a dimmer trial and arm the power check
        r.out_level = {1'b0, s.want_level};
        r.out_relay = 1'b0;
        if (s.check_count == 16'd0)
          r.check_count = c.check_delay_ticks;
      end
    end else begin
      r = drive_level(r, c, {1'b0, s.want_level}, overload, dimfail);
      r = drive_relay(r, 1'b0, overload, dimfail);
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/relay_dimmer_safety_controller.sv =====
`timescale 1ns / 1ps

// Relay and dimmer supervisor.
// Input stream: one command or event per word. s_tuser carries the action code,
// s_tdata the level, requested relay state, error flags and measured power.
// Output stream: one result word per input word with the actual drive, the
// intended state, the powered flag and the per-word reports.
// Configuration: APB-style port, seven registers at byte addresses 0..24;
// write only while the stream is idle.
// Latency: a result is valid the cycle after its input word is accepted.
// Throughput: one word per cycle when not stalled; the whole update is a few
// levels of compare and select logic between the state registers and the result
// register. The input side is ready whenever the result register is empty or
// being drained, so a stalled receiver stops input after one word is buffered.
// Reset (rst, synchronous) clears the drive and intended state, loads the
// power-up countdown with POWERUP_TICKS, empties the result register and
// restores the register defaults.
module relay_dimmer_safety_controller #(
  parameter int unsigned POWERUP_TICKS = rdsc_pkg::PowerupTicksDefault
) (
  input  logic                          clk,
  input  logic                          rst,
  // value[7:0], relay_req[8], err_chip_temp[9], err_over_current[10],
  // err_over_current_dimmer[11], err_dimmer_temp[12], err_dimmer_on[13],
  // power_usage_mw[45:14], zero fill [47:46]
  input  logic [rdsc_pkg::InDataW-1:0]  s_tdata,
  // action[2:0]
  input  logic [rdsc_pkg::InUserW-1:0]  s_tuser,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // relay_drive[0], dimmer_drive[8:1], intended_relay[9], intended_dimmer[16:10],
  // dimmer_powered[17], powered_report[18], forced_event[20:19],
  // store_request[21], zero fill [23:22]
  output logic [rdsc_pkg::OutDataW-1:0] m_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rdsc_pkg::CfgAddrW-1:0] paddr,
  input  logic [rdsc_pkg::CfgDataW-1:0] pwdata,
  output logic [rdsc_pkg::CfgDataW-1:0] prdata,
  output logic                          pready
);
  import rdsc_pkg::*;

  cfg_t     cfg;
  reg_idx_t reg_idx;
  sup_t     st;
  sup_t     st_next;
  logic     in_fire;

  action_t        action;
  logic [7:0]     value;
  logic           relay_req;
  logic           overload;
  logic           dimfail;
  logic signed [31:0] power_mw;
  logic           rep_powered;
  forced_t        forced;
  logic           check_fail;

  logic [OutDataW-1:0] result;

  // Unpack the input word
  assign action    = action_t'(s_tuser);
  assign value     = s_tdata[7:0];
  assign relay_req = s_tdata[8];
  assign overload  = s_tdata[9] | s_tdata[10];
  assign dimfail   = s_tdata[11] | s_tdata[12] | s_tdata[13];
  assign power_mw  = $signed(s_tdata[45:14]);

  assign s_tready = !m_tvalid || m_tready;
  assign in_fire  = s_tvalid && s_tready;

  // Configuration port
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.switching_allowed        <= 1'b1;
      cfg.dimming_allowed          <= 1'b0;
      cfg.boot_dim_try_allowed     <= 1'b1;
      cfg.power_threshold_mw       <= 16'd0;
      cfg.power_threshold_uncal_mw <= 16'd0;
      cfg.power_zero_calibrated    <= 1'b0;
      cfg.check_delay_ticks        <= 16'd1;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_SWITCHING_ALLOWED:   cfg.switching_allowed        <= pwdata[0];
        REG_DIMMING_ALLOWED:     cfg.dimming_allowed          <= pwdata[0];
        REG_BOOT_DIM_TRY:        cfg.boot_dim_try_allowed     <= pwdata[0];
        REG_POWER_THRESHOLD:     cfg.power_threshold_mw       <= pwdata[15:0];
        REG_POWER_THRESHOLD_UNC: cfg.power_threshold_uncal_mw <= pwdata[15:0];
        REG_POWER_ZERO_CAL:      cfg.power_zero_calibrated    <= pwdata[0];
        REG_CHECK_DELAY:         cfg.check_delay_ticks        <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    case (reg_idx)
      REG_SWITCHING_ALLOWED:   prdata = {31'd0, cfg.switching_allowed};
      REG_DIMMING_ALLOWED:     prdata = {31'd0, cfg.dimming_allowed};
      REG_BOOT_DIM_TRY:        prdata = {31'd0, cfg.boot_dim_try_allowed};
      REG_POWER_THRESHOLD:     prdata = {16'd0, cfg.power_threshold_mw};
      REG_POWER_THRESHOLD_UNC: prdata = {16'd0, cfg.power_threshold_uncal_mw};
      REG_POWER_ZERO_CAL:      prdata = {31'd0, cfg.power_zero_calibrated};
      REG_CHECK_DELAY:         prdata = {16'd0, cfg.check_delay_ticks};
      default:                 prdata = '0;
    endcase
  end

  // Power check compare against both thresholds
  assign check_fail =
    (power_mw < $signed({16'd0, cfg.power_threshold_mw})) ||
    ((power_mw < $signed({16'd0, cfg.power_threshold_uncal_mw})) &&
     !cfg.power_zero_calibrated);

  // Apply one command or event to the supervisor state
  always_comb begin
    st_next           = st;
    st_next.store_req = 1'b0;
    rep_powered       = 1'b0;
    forced            = FORCED_NONE;
    case (action)
      ACT_SET_DIMMER: begin
        if (cfg.switching_allowed) begin
          st_next = save_state(st_next, 1'b0, (value > {1'b0, MaxLevelPct}) ?
                               MaxLevelPct : value[6:0]);
          st_next = resolve(st_next, cfg, overload, dimfail);
        end
      end
      ACT_SET_RELAY: begin
        if (cfg.switching_allowed)
          st_next = drive_relay(st_next, relay_req, overload, dimfail);
      end
      ACT_SET_INTENSITY: begin
        if (cfg.switching_allowed)
          st_next = drive_level(st_next, cfg, value, overload, dimfail);
      end
      ACT_TICK: begin
        if (st.powerup_count != 16'd0) begin
          st_next.powerup_count = st.powerup_count - 16'd1;
          if (st.powerup_count == 16'd1)
            rep_powered = 1'b1;
        end
        if (st.check_count != 16'd0) begin
          st_next.check_count = st.check_count - 16'd1;
          if (st.check_count == 16'd1) begin
            // Countdown expired: judge the dimmer by its measured power
            st_next.power_checked = 1'b1;
            if (cfg.dimming_allowed && st_next.want_level != 7'd0) begin
              if (check_fail) begin
                st_next.power_measured = 1'b0;
                st_next = fall_back(st_next);
              end else begin
                st_next.power_measured = 1'b1;
              end
              rep_powered = 1'b1;
            end
            st_next = resolve(st_next, cfg, overload, dimfail);
          end
        end
      end
      ACT_DIMMER_FAULT: begin
        st_next.out_relay = 1'b1;
        st_next.out_level = 8'd0;
        forced            = FORCED_RELAY_ON;
      end
      ACT_SWITCH_FAULT: begin
        st_next.out_relay = 1'b0;
        st_next.out_level = 8'd0;
        st_next           = save_state(st_next, 1'b0, 7'd0);
        forced            = FORCED_SWITCH_OFF;
      end
      ACT_GOING_TO_DFU: begin
        st_next = drive_relay(st_next, 1'b1, overload, dimfail);
      end
      default: ;
    endcase
  end

  // Pack the result word
  assign result = {2'b00, st_next.store_req, forced, rep_powered,
                   circuit_powered(st_next), st_next.want_level, st_next.want_relay,
                   st_next.out_level, st_next.out_relay};

  // Advance the state on each accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      st.want_relay     <= 1'b0;
      st.want_level     <= 7'd0;
      st.saved_relay    <= 1'b0;
      st.saved_level    <= 7'd0;
      st.out_relay      <= 1'b0;
      st.out_level      <= 8'd0;
      st.power_checked  <= 1'b0;
      st.power_measured <= 1'b0;
      st.powerup_count  <= 16'(POWERUP_TICKS);
      st.check_count    <= 16'd0;
      st.store_req      <= 1'b0;
    end else if (in_fire) begin
      st <= st_next;
    end
  end

  // Hold the result until the receiver takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (in_fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire)
      m_tdata <= result;
  end

endmodule

// ===== test/supervisor_check.sv =====
`timescale 1ns / 1ps

// Watches the command, result and register channels of the relay/dimmer
// supervisor, predicts every result word and compares it field by field.
module supervisor_check (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [rdsc_pkg::InDataW-1:0]   s_tdata,
  input  logic [rdsc_pkg::InUserW-1:0]   s_tuser,
  input  logic                           s_tvalid,
  input  logic                           s_tready,
  input  logic [rdsc_pkg::OutDataW-1:0]  m_tdata,
  input  logic                           m_tvalid,
  input  logic                           m_tready,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [rdsc_pkg::CfgAddrW-1:0]  paddr,
  input  logic [rdsc_pkg::CfgDataW-1:0]  pwdata,
  input  logic                           pready,
  output int                             fail_count,
  output int                             pending
);
  import rdsc_pkg::*;

  // Command word, lowest field last
  typedef struct packed {
    logic [1:0]  pad;
    logic [31:0] power_mw;
    logic        err_dimmer_on;
    logic        err_dimmer_temp;
    logic        err_oc_dimmer;
    logic        err_over_current;
    logic        err_chip_temp;
    logic        relay_req;
    logic [7:0]  value;
  } cmd_word_t;

  // Result word, lowest field last
  typedef struct packed {
    logic [1:0] pad;
    logic       store;
    logic [1:0] forced;
    logic       powered_rep;
    logic       powered;
    logic [6:0] goal_level;
    logic       goal_relay;
    logic [7:0] dim_drive;
    logic       relay_drive;
  } drive_word_t;

  cfg_t cfg;

  // Supervisor state as the block should hold it
  logic        goal_relay, stored_relay, drv_relay;
  logic [6:0]  goal_level, stored_level;
  logic [7:0]  drv_level;
  logic        pwr_checked, pwr_seen;
  logic [15:0] boot_ticks_left, check_ticks_left;

  // Per-word interlock flags and reports
  logic overload, dim_fault, note_powered, note_store;

  drive_word_t drive_due[$];

  function automatic logic dimmer_live();
    return (boot_ticks_left == 16'd0) || pwr_seen;
  endfunction

  function automatic void record_goal(logic relay, logic [6:0] level);
    goal_relay = relay;
    goal_level = level;
    if (relay != stored_relay || level != stored_level) begin
      stored_relay = relay;
      stored_level = level;
      note_store = 1'b1;
    end
  endfunction

  function automatic void relay_try(logic on);
    if (on && !(dim_fault || !overload)) return;
    if (!on && dim_fault) return;
    drv_relay = on;
  endfunction

  function automatic void level_try(logic [7:0] v);
    if (v != 8'd0 && (!cfg.dimming_allowed || dim_fault || overload || !dimmer_live()))
      return;
    drv_level = v;
  endfunction

  function automatic void relay_fallback();
    drv_relay = 1'b1;
    drv_level = 8'd0;
    record_goal(1'b1, 7'd0);
  endfunction

  // Start a dimmer trial before the circuit is known to be powered
  function automatic bit trial_start(logic [6:0] lvl);
    if (pwr_checked || dim_fault || overload || lvl == 7'd0 || !cfg.boot_dim_try_allowed)
      return 1'b0;
    drv_level = {1'b0, lvl};
    drv_relay = 1'b0;
    if (check_ticks_left == 16'd0)
      check_ticks_left = cfg.check_delay_ticks;
    return 1'b1;
  endfunction

  // Judge the measured power at the end of the trial delay
  function automatic void power_verdict(logic [31:0] raw);
    longint pw;
    pw = longint'($signed(raw));
    pwr_checked = 1'b1;
    if (!cfg.dimming_allowed || goal_level == 7'd0) return;
    if (pw < longint'(cfg.power_threshold_mw) ||
        (pw < longint'(cfg.power_threshold_uncal_mw) && !cfg.power_zero_calibrated)) begin
      pwr_seen = 1'b0;
      relay_fallback();
    end else begin
      pwr_seen = 1'b1;
    end
    note_powered = 1'b1;
  endfunction

  // Move the drive towards the intended state
  function automatic void settle();
    if (goal_relay) begin
      relay_try(1'b1);
      level_try(8'd0);
      return;
    end
    if (goal_level != 7'd0 && (!cfg.dimming_allowed || dim_fault || overload ||
                               (!dimmer_live() && pwr_checked))) begin
      relay_try(1'b1);
      level_try(8'd0);
      return;
    end
    if (cfg.dimming_allowed && !pwr_checked && !dimmer_live() && goal_level != 7'd0) begin
      if (!trial_start(goal_level))
        relay_fallback();
      return;
    end
    level_try({1'b0, goal_level});
    relay_try(1'b0);
  endfunction

  function automatic drive_word_t predict_drive(cmd_word_t c, action_t act);
    drive_word_t r;
    forced_t forced;
    overload     = c.err_chip_temp | c.err_over_current;
    dim_fault    = c.err_oc_dimmer | c.err_dimmer_temp | c.err_dimmer_on;
    note_powered = 1'b0;
    note_store   = 1'b0;
    forced       = FORCED_NONE;
    case (act)
      ACT_SET_DIMMER: begin
        if (cfg.switching_allowed) begin
          record_goal(1'b0, (c.value > {1'b0, MaxLevelPct}) ? MaxLevelPct : c.value[6:0]);
          settle();
        end
      end
      ACT_SET_RELAY: begin
        if (cfg.switching_allowed) relay_try(c.relay_req);
      end
      ACT_SET_INTENSITY: begin
        if (cfg.switching_allowed) level_try(c.value);
      end
      ACT_TICK: begin
        if (boot_ticks_left != 16'd0) begin
          boot_ticks_left = boot_ticks_left - 16'd1;
          if (boot_ticks_left == 16'd0) note_powered = 1'b1;
        end
        if (check_ticks_left != 16'd0) begin
          check_ticks_left = check_ticks_left - 16'd1;
          if (check_ticks_left == 16'd0) begin
            power_verdict(c.power_mw);
            settle();
          end
        end
      end
      ACT_DIMMER_FAULT: begin
        drv_relay = 1'b1;
        drv_level = 8'd0;
        forced    = FORCED_RELAY_ON;
      end
      ACT_SWITCH_FAULT: begin
        drv_level = 8'd0;
        drv_relay = 1'b0;
        record_goal(1'b0, 7'd0);
        forced = FORCED_SWITCH_OFF;
      end
      ACT_GOING_TO_DFU: relay_try(1'b1);
      default: ;
    endcase
    r.pad         = 2'b00;
    r.relay_drive = drv_relay;
    r.dim_drive   = drv_level;
    r.goal_relay  = goal_relay;
    r.goal_level  = goal_level;
    r.powered     = dimmer_live();
    r.powered_rep = note_powered;
    r.forced      = forced;
    r.store       = note_store;
    return r;
  endfunction

  task automatic check_field(string field, longint want, longint got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
      fail_count++;
    end
  endtask

  initial fail_count = 0;
  initial pending = 0;

  always @(posedge clk) begin : watch
    drive_word_t got;
    drive_word_t want;
    if (rst) begin
      cfg.switching_allowed        = 1'b1;
      cfg.dimming_allowed          = 1'b0;
      cfg.boot_dim_try_allowed     = 1'b1;
      cfg.power_threshold_mw       = 16'd0;
      cfg.power_threshold_uncal_mw = 16'd0;
      cfg.power_zero_calibrated    = 1'b0;
      cfg.check_delay_ticks        = 16'd1;
      goal_relay       = 1'b0;
      goal_level       = 7'd0;
      stored_relay     = 1'b0;
      stored_level     = 7'd0;
      drv_relay        = 1'b0;
      drv_level        = 8'd0;
      pwr_checked      = 1'b0;
      pwr_seen         = 1'b0;
      boot_ticks_left  = 16'(PowerupTicksDefault);
      check_ticks_left = 16'd0;
      drive_due.delete();
    end else begin
      // Track register writes
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[4:2]))
          REG_SWITCHING_ALLOWED:   cfg.switching_allowed        = pwdata[0];
          REG_DIMMING_ALLOWED:     cfg.dimming_allowed          = pwdata[0];
          REG_BOOT_DIM_TRY:        cfg.boot_dim_try_allowed     = pwdata[0];
          REG_POWER_THRESHOLD:     cfg.power_threshold_mw       = pwdata[15:0];
          REG_POWER_THRESHOLD_UNC: cfg.power_threshold_uncal_mw = pwdata[15:0];
          REG_POWER_ZERO_CAL:      cfg.power_zero_calibrated    = pwdata[0];
          REG_CHECK_DELAY:         cfg.check_delay_ticks        = pwdata[15:0];
          default: ;
        endcase
      end
      // Compare the result word against the oldest prediction
      if (m_tvalid && m_tready) begin
        got = drive_word_t'(m_tdata);
        if (drive_due.size() == 0) begin
          $display("%0t: result word, expected none, got %h", $time, m_tdata);
          fail_count++;
        end else begin
          want = drive_due.pop_front();
          check_field("relay_drive", want.relay_drive, got.relay_drive);
          check_field("dimmer_drive", want.dim_drive, got.dim_drive);
          check_field("intended_relay", want.goal_relay, got.goal_relay);
          check_field("intended_dimmer", want.goal_level, got.goal_level);
          check_field("dimmer_powered", want.powered, got.powered);
          check_field("powered_report", want.powered_rep, got.powered_rep);
          check_field("forced_event", want.forced, got.forced);
          check_field("store_request", want.store, got.store);
        end
      end
      // Predict the word just accepted
      if (s_tvalid && s_tready)
        drive_due.push_back(predict_drive(cmd_word_t'(s_tdata), action_t'(s_tuser)));
    end
    pending = drive_due.size();
  end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import rdsc_pkg::*;

  // Error flag masks in command word order
  localparam logic [4:0] ERR_NONE         = 5'b00000;
  localparam logic [4:0] ERR_CHIP_TEMP    = 5'b00001;
  localparam logic [4:0] ERR_OVER_CURRENT = 5'b00010;
  localparam logic [4:0] ERR_DIMMER_TEMP  = 5'b01000;
  localparam logic [4:0] ERR_DIMMER_ON    = 5'b10000;

  logic                clk;
  logic                rst;
  logic [InDataW-1:0]  s_tdata;
  logic [InUserW-1:0]  s_tuser;
  logic                s_tvalid;
  logic                s_tready;
  logic [OutDataW-1:0] m_tdata;
  logic                m_tvalid;
  logic                m_tready;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [CfgAddrW-1:0] paddr;
  logic [CfgDataW-1:0] pwdata;
  logic [CfgDataW-1:0] prdata;
  logic                pready;

  int fail_count;
  int pending;
  int send_gap_pct;
  int recv_gap_pct;
  int recv_hold;

  relay_dimmer_safety_controller u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  supervisor_check u_check (
    .clk        (clk),
    .rst        (rst),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .m_tdata    (m_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .pready     (pready),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Give up if the run hangs
  initial begin
    #4_000_000;
    $display("FAILURE");
    $finish;
  end

  // Receiver: stall at random, or hold off for a requested stretch
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (recv_hold > 0) begin
        m_tready <= 1'b0;
        recv_hold--;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_gap_pct);
      end
    end
  end

  // Offer one command word and hold it until accepted
  task automatic put_cmd(action_t act, logic [7:0] val, logic ron, logic [4:0] errs,
                         logic [31:0] pwr);
    while ($urandom_range(99) < send_gap_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= {2'b00, pwr, errs, ron, val};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic rand_cmd();
    int pick;
    action_t act;
    logic [7:0] val;
    logic [4:0] errs;
    logic [31:0] pwr;
    pick = $urandom_range(99);
    if (pick < 25)      act = ACT_SET_DIMMER;
    else if (pick < 40) act = ACT_SET_RELAY;
    else if (pick < 52) act = ACT_SET_INTENSITY;
    else if (pick < 82) act = ACT_TICK;
    else if (pick < 87) act = ACT_DIMMER_FAULT;
    else if (pick < 91) act = ACT_SWITCH_FAULT;
    else if (pick < 96) act = ACT_GOING_TO_DFU;
    else                act = ACT_UNUSED;
    val = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(100));
    for (int i = 0; i < 5; i++)
      errs[i] = ($urandom_range(7) == 0);
    case ($urandom_range(2))
      0:       pwr = $urandom;
      1:       pwr = $urandom_range(70000);
      default: pwr = -$urandom_range(50);
    endcase
    put_cmd(act, val, 1'($urandom_range(1)), errs, pwr);
  endtask

  // Drop valid and wait for every result word to come back
  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic reg_write(reg_idx_t idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic setup_phase(logic sw, logic dim, logic boot, logic [15:0] thr,
                             logic [15:0] thr_unc, logic zero_cal, logic [15:0] dly);
    drain();
    reg_write(REG_SWITCHING_ALLOWED, {31'd0, sw});
    reg_write(REG_DIMMING_ALLOWED, {31'd0, dim});
    reg_write(REG_BOOT_DIM_TRY, {31'd0, boot});
    reg_write(REG_POWER_THRESHOLD, {16'd0, thr});
    reg_write(REG_POWER_THRESHOLD_UNC, {16'd0, thr_unc});
    reg_write(REG_POWER_ZERO_CAL, {31'd0, zero_cal});
    reg_write(REG_CHECK_DELAY, {16'd0, dly});
  endtask

  initial begin
    rst          = 1'b1;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    s_tuser      = ACT_SET_DIMMER;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    send_gap_pct = 7;
    recv_gap_pct = 72;
    recv_hold    = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Boot trial with zero check delay: the check never arms
    setup_phase(1'b1, 1'b1, 1'b1, 16'd500, 16'd800, 1'b0, 16'd0);
    put_cmd(ACT_SET_DIMMER, 8'd60, 1'b0, ERR_NONE, 32'd0);
    put_cmd(ACT_TICK, 8'd0, 1'b0, ERR_NONE, 32'd0);
    put_cmd(ACT_SET_DIMMER, 8'd255, 1'b1, ERR_NONE, 32'h8000_0000);
    put_cmd(ACT_SET_INTENSITY, 8'd255, 1'b0, ERR_NONE, 32'h7FFF_FFFF);
    put_cmd(ACT_SET_RELAY, 8'd0, 1'b1, ERR_OVER_CURRENT, 32'd0);
    put_cmd(ACT_UNUSED, 8'hFF, 1'b1, 5'b11111, 32'hFFFF_FFFF);
    put_cmd(ACT_GOING_TO_DFU, 8'd0, 1'b0, ERR_NONE, 32'd0);

    // Armed trial, then the power check on the second tick
    setup_phase(1'b1, 1'b1, 1'b1, 16'd500, 16'd800, 1'b0, 16'd2);
    put_cmd(ACT_SET_DIMMER, 8'd40, 1'b0, ERR_NONE, 32'd0);
    put_cmd(ACT_TICK, 8'd0, 1'b0, ERR_NONE, 32'h8000_0000);
    put_cmd(ACT_TICK, 8'd0, 1'b0, ERR_NONE,
            $urandom_range(1) ? 32'h7FFF_FFFF : 32'd600);
    put_cmd(ACT_SET_DIMMER, 8'd30, 1'b0, ERR_DIMMER_ON, 32'd0);
    put_cmd(ACT_SET_RELAY, 8'd0, 1'b0, ERR_DIMMER_TEMP, 32'd0);
    put_cmd(ACT_SET_INTENSITY, 8'd100, 1'b0, ERR_CHIP_TEMP, 32'd0);
    put_cmd(ACT_DIMMER_FAULT, 8'd0, 1'b0, ERR_NONE, 32'd0);
    put_cmd(ACT_SWITCH_FAULT, 8'd0, 1'b0, ERR_NONE, 32'd0);
    put_cmd(ACT_SET_INTENSITY, 8'd0, 1'b0, ERR_NONE, 32'd0);

    // Switching locked: set commands refused, faults still act
    setup_phase(1'b0, 1'b1, 1'b1, 16'd500, 16'd800, 1'b0, 16'd2);
    put_cmd(ACT_SET_DIMMER, 8'd80, 1'b0, ERR_NONE, 32'd0);
    put_cmd(ACT_SET_RELAY, 8'd0, 1'b1, ERR_NONE, 32'd0);
    put_cmd(ACT_SET_INTENSITY, 8'd200, 1'b0, ERR_NONE, 32'd0);
    put_cmd(ACT_TICK, 8'd0, 1'b0, ERR_NONE, 32'd0);
    put_cmd(ACT_DIMMER_FAULT, 8'd0, 1'b0, ERR_NONE, 32'd0);
    put_cmd(ACT_GOING_TO_DFU, 8'd0, 1'b0, ERR_NONE, 32'd0);
    put_cmd(ACT_SWITCH_FAULT, 8'd0, 1'b0, ERR_NONE, 32'd0);

    // Random phases over several register settings
    for (int ph = 0; ph < 5; ph++) begin
      if (ph == 2) begin
        send_gap_pct = 72;
        recv_gap_pct = 7;
      end
      if (ph == 4) begin
        send_gap_pct = 0;
        recv_gap_pct = 0;
      end
      case (ph)
        0: setup_phase(1'b1, 1'b1, 1'b1, 16'd0, 16'd0, 1'b1, 16'd1);
        1: setup_phase(1'b1, 1'b1, 1'b0, 16'hFFFF, 16'hFFFF, 1'b0, 16'hFFFF);
        2: setup_phase($urandom_range(3) != 0, 1'($urandom_range(1)),
                       1'($urandom_range(1)), 16'($urandom), 16'($urandom),
                       1'($urandom_range(1)), 16'($urandom_range(1, 8)));
        3: setup_phase(1'b1, 1'b0, 1'b1, 16'($urandom), 16'($urandom),
                       1'($urandom_range(1)), 16'($urandom_range(1, 8)));
        default: setup_phase(1'b1, 1'b1, 1'($urandom_range(1)),
                             16'($urandom_range(2000)), 16'($urandom_range(2000)),
                             1'($urandom_range(1)), 16'($urandom_range(1, 4)));
      endcase
      // Hold off the receiver long enough to back up the input
      if (ph == 1) recv_hold = 60;
      repeat (300) rand_cmd();
    end

    drain();
    repeat (4) @(negedge clk);
    if (fail_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
